// File: sv/mftc_pkg.sv
// ----------------------------------------------------------------------------
// MOX fuel thermal conductivity - shared package
// Field widths, payload structs, register indexes and the fixed-point
// constants of the conductivity correlation.
// ----------------------------------------------------------------------------
package mftc_pkg;

  // Default width of the meaningful part of the cell index.
  localparam int CELL_ID_BITS_DEF = 20;

  // Field widths.
  localparam int TAG_W    = 20;
  localparam int TEMP_W   = 16;
  localparam int BURNUP_W = 18;
  localparam int PORO_W   = 16;
  localparam int OM_W     = 18;
  localparam int COND_W   = 24;

  // Configuration port.
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int PHONON_COEFF_W = 24;
  localparam int CUBIC_COEFF_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_PHONON_TEMP_COEFF      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ELECTRONIC_CUBIC_COEFF = 2'd1;

  localparam logic [PHONON_COEFF_W-1:0] PHONON_COEFF_RST = 24'd1239098;
  localparam logic [CUBIC_COEFF_W-1:0]  CUBIC_COEFF_RST  = 20'd21499;

  // Pipeline step counts of the iterative units.
  localparam int SQ_STEPS = 17;  // root bits of a 34-bit radicand
  localparam int DP_STEPS = 32;  // quotient bits of the phonon division
  localparam int KD_STEPS = 24;  // quotient bits of the porosity division

  // Radicand 2^33 + x bias in Q.32: (2 + 0.00931) scaled.
  localparam logic [33:0] RAD_TOP    = 34'd8629920738;
  localparam logic [16:0] SQRT_COEF  = 17'd100139;     // 1.528 in Q.16
  localparam logic [28:0] OFFSET_A   = 29'd453119050;  // 0.1055 in Q.32
  // Fractional burnup term: burnup * 11 * 2^28 / 1484375, split into an
  // integer multiple and the fraction burnup * 368141 / 1484375. The fraction
  // is formed as burnup * 136345367634 / 2^39, which is exact for every
  // 18-bit burnup; the reciprocal is held as an upper and a lower half.
  localparam logic [10:0] TAU_INT    = 11'd1989;
  localparam logic [17:0] TAU_RCP_HI = 18'd260058;  // reciprocal >> 19
  localparam logic [18:0] TAU_RCP_LO = 19'd78930;   // reciprocal mod 2^19
  localparam logic [PORO_W-1:0] PORO_CAP = 16'd62259;  // 0.95 in Q0.16
  localparam logic [9:0]  PM_SCALE   = 10'd1000;
  localparam logic [9:0]  DV_SCALE   = 10'd864;
  localparam logic [31:0] SUM_CAP    = 32'h8000_0000;
  localparam logic [COND_W-1:0] RES_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [TAG_W-1:0]    cell_id;
    logic [TEMP_W-1:0]   temperature;
    logic [BURNUP_W-1:0] burnup;
    logic [PORO_W-1:0]   porosity_frac;
    logic [OM_W-1:0]     om_ratio;
  } mftc_in_t;

  typedef struct packed {
    logic [TAG_W-1:0]  cell_tag;
    logic [COND_W-1:0] conductivity;
    logic              saturated;
  } mftc_out_t;

endpackage

// File: sv/mox_fuel_thermal_conductivity_top.sv
// ----------------------------------------------------------------------------
// MOX fuel thermal conductivity - top level
// Evaluates k = (1/(A + B*T) + C*T^3) * alpha for one mesh cell per cycle
// in a fully pipelined datapath, unless the output stalls.
// ----------------------------------------------------------------------------
//  Channel  | Signals                               | Direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_ready, in_data           | in
//  output   | out_valid, out_ready, out_data        | out
//  config   | cfg_valid, cfg_ready, cfg_index/data  | in
//
// One cell is taken per cycle unless the output stalls; there are 81 register
// stages from the entry stage through to the output register.
// The depth comes from the bit-serial square root (17 stages), the phonon
// division (32 stages) and the porosity division (24 stages).
// The whole pipeline advances together whenever the output register is empty
// or its result is being taken, so a stalled output freezes every stage.
// Reset clears the valid bits and loads the coefficient reset values.
// ----------------------------------------------------------------------------
module mox_fuel_thermal_conductivity_top #(
  parameter int CELL_ID_BITS = mftc_pkg::CELL_ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mftc_pkg::mftc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mftc_pkg::mftc_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mftc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mftc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mftc_pkg::*;

  localparam logic [TAG_W-1:0] TAG_MASK = (CELL_ID_BITS >= TAG_W) ? {TAG_W{1'b1}} :
                                          TAG_W'((64'd1 << CELL_ID_BITS) - 64'd1);

  // Square-root stages, which also carry the burnup partial products.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic [33:0]      rad;
    logic [16:0]      root;
    logic [19:0]      rem;
    logic [35:0]      tph;
    logic [17:0]      tpl;
    logic [28:0]      thi;
    logic [35:0]      bt;
    logic [15:0]      t;
    logic [31:0]      t2;
    logic [25:0]      pm;
    logic [27:0]      dv;
  } sq_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic [33:0]      amul;
    logic [29:0]      tau;
    logic [35:0]      bt;
    logic [47:0]      t3;
    logic [25:0]      pm;
    logic [27:0]      dv;
  } sa_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic [36:0]      u;
    logic [43:0]      ch;
    logic [19:0]      cl;
    logic [25:0]      pm;
    logic [27:0]      dv;
  } sb_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic             dbad;
    logic             dsmall;
    logic [36:0]      d;
    logic [36:0]      r;
    logic [31:0]      q;
    logic [24:0]      el;
    logic [25:0]      pm;
    logic [27:0]      dv;
  } dp_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic             dbad;
    logic [31:0]      s;
    logic [25:0]      pm;
    logic [27:0]      dv;
  } sd_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic             dbad;
    logic [57:0]      n;
    logic [27:0]      dv;
  } se_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             flag;
    logic             bad;
    logic [27:0]      r;
    logic [23:0]      nlo;
    logic [23:0]      q;
    logic [27:0]      dv;
  } kd_t;

  logic [PHONON_COEFF_W-1:0] phonon_coeff;
  logic [CUBIC_COEFF_W-1:0]  cubic_coeff;

  logic adv;

  sq_t sq [0:SQ_STEPS];
  sa_t sa;
  sb_t sb;
  dp_t dp [0:DP_STEPS];
  sd_t sd;
  se_t se;
  kd_t kd [0:KD_STEPS];

  logic [SQ_STEPS:0] sq_v;
  logic              sa_v;
  logic              sb_v;
  logic [DP_STEPS:0] dp_v;
  logic              sd_v;
  logic              se_v;
  logic [KD_STEPS:0] kd_v;

  sq_t       sq0_next;
  sa_t       sa_next;
  sb_t       sb_next;
  dp_t       dp0_next;
  sd_t       sd_next;
  se_t       se_next;
  kd_t       kd0_next;
  mftc_out_t out_next;

  // The pipeline moves as one whenever the output register can be refilled.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Coefficient registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      phonon_coeff <= PHONON_COEFF_RST;
      cubic_coeff  <= CUBIC_COEFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHONON_TEMP_COEFF:      phonon_coeff <= cfg_data[PHONON_COEFF_W-1:0];
        REG_ELECTRONIC_CUBIC_COEFF: cubic_coeff  <= cfg_data[CUBIC_COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v      <= '0;
      sa_v      <= 1'b0;
      sb_v      <= 1'b0;
      dp_v      <= '0;
      sd_v      <= 1'b0;
      se_v      <= 1'b0;
      kd_v      <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sq_v      <= {sq_v[SQ_STEPS-1:0], in_valid};
      sa_v      <= sq_v[SQ_STEPS];
      sb_v      <= sa_v;
      dp_v      <= {dp_v[DP_STEPS-1:0], sb_v};
      sd_v      <= dp_v[DP_STEPS];
      se_v      <= sd_v;
      kd_v      <= {kd_v[KD_STEPS-1:0], se_v};
      out_valid <= kd_v[KD_STEPS];
    end
  end

  // Entry stage: radicand with clamp, burnup products, porosity factors,
  // B*T and T^2.
  always_comb begin
    logic [33:0]       om_sh;
    logic              rad_neg;
    logic [PORO_W-1:0] pc;
    logic [36:0]       tlo;
    logic [39:0]       btf;
    logic [16:0]       pinv;
    logic [17:0]       pden;
    om_sh   = {in_data.om_ratio, 16'd0};
    rad_neg = om_sh > RAD_TOP;
    pc      = (in_data.porosity_frac > PORO_CAP) ? PORO_CAP : in_data.porosity_frac;
    tlo     = in_data.burnup * TAU_RCP_LO;
    btf     = phonon_coeff * in_data.temperature;
    pinv    = 17'd65536 - {1'b0, pc};
    pden    = 18'd65536 + {1'b0, pc, 1'b0};

    sq0_next.tag  = in_data.cell_id & TAG_MASK;
    sq0_next.flag = rad_neg;
    sq0_next.rad  = rad_neg ? '0 : RAD_TOP - om_sh;
    sq0_next.root = '0;
    sq0_next.rem  = '0;
    sq0_next.tph  = in_data.burnup * TAU_RCP_HI;
    sq0_next.tpl  = tlo[36:19];
    sq0_next.thi  = in_data.burnup * TAU_INT;
    sq0_next.bt   = btf[39:4];
    sq0_next.t    = in_data.temperature;
    sq0_next.t2   = in_data.temperature * in_data.temperature;
    sq0_next.pm   = pinv * PM_SCALE;
    sq0_next.dv   = pden * DV_SCALE;
  end

  // One root bit per stage.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    sq_t         nx;
    logic [19:0] acc;
    logic [19:0] trial;
    always_comb begin
      nx    = sq[j];
      acc   = {sq[j].rem[17:0], sq[j].rad[33-2*j -: 2]};
      trial = {1'b0, sq[j].root, 2'b01};
      if (acc >= trial) begin
        nx.rem  = acc - trial;
        nx.root = {sq[j].root[15:0], 1'b1};
      end else begin
        nx.rem  = acc;
        nx.root = {sq[j].root[15:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[j+1] <= nx;
      end
    end
  end

  // Square-root coefficient, burnup sum and T^3.
  always_comb begin
    logic [36:0] tsum;
    tsum         = 37'(sq[SQ_STEPS].tph) + 37'(sq[SQ_STEPS].tpl);
    sa_next.tag  = sq[SQ_STEPS].tag;
    sa_next.flag = sq[SQ_STEPS].flag;
    sa_next.amul = sq[SQ_STEPS].root * SQRT_COEF;
    sa_next.tau  = 30'(sq[SQ_STEPS].thi) + 30'(tsum[36:20]);
    sa_next.bt   = sq[SQ_STEPS].bt;
    sa_next.t3   = sq[SQ_STEPS].t2 * sq[SQ_STEPS].t;
    sa_next.pm   = sq[SQ_STEPS].pm;
    sa_next.dv   = sq[SQ_STEPS].dv;
  end

  // Phonon denominator before the offset, and the two halves of C*T^3.
  always_comb begin
    logic [43:0] clf;
    clf          = cubic_coeff * sa.t3[23:0];
    sb_next.tag  = sa.tag;
    sb_next.flag = sa.flag;
    sb_next.u    = 37'(sa.amul) + 37'(sa.tau) + 37'(sa.bt);
    sb_next.ch   = cubic_coeff * sa.t3[47:24];
    sb_next.cl   = clf[43:24];
    sb_next.pm   = sa.pm;
    sb_next.dv   = sa.dv;
  end

  // Offset subtraction, range checks and set-up of the phonon division.
  always_comb begin
    logic [44:0] esum;
    esum            = 45'(sb.ch) + 45'(sb.cl);
    dp0_next.tag    = sb.tag;
    dp0_next.flag   = sb.flag;
    dp0_next.d      = sb.u - 37'(OFFSET_A);
    dp0_next.dbad   = sb.u <= 37'(OFFSET_A);
    dp0_next.dsmall = dp0_next.d[36:17] == '0;
    dp0_next.r      = 37'(1) << 16;
    dp0_next.q      = '0;
    dp0_next.el     = esum[44:20];
    dp0_next.pm     = sb.pm;
    dp0_next.dv     = sb.dv;
  end

  // Restoring division of 2^48 by D, one quotient bit per stage.
  for (genvar j = 0; j < DP_STEPS; j++) begin : g_dp
    dp_t         nx;
    logic [37:0] r2;
    always_comb begin
      nx = dp[j];
      r2 = {dp[j].r, 1'b0};
      if (r2 >= {1'b0, dp[j].d}) begin
        nx.r = 37'(r2 - {1'b0, dp[j].d});
        nx.q = {dp[j].q[30:0], 1'b1};
      end else begin
        nx.r = r2[36:0];
        nx.q = {dp[j].q[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dp[j+1] <= nx;
      end
    end
  end

  // Sum of the two terms, capped.
  always_comb begin
    logic [32:0] qsum;
    qsum         = 33'(dp[DP_STEPS].q) + 33'(dp[DP_STEPS].el);
    sd_next.tag  = dp[DP_STEPS].tag;
    sd_next.flag = dp[DP_STEPS].flag;
    sd_next.dbad = dp[DP_STEPS].dbad;
    if (dp[DP_STEPS].dsmall || qsum > 33'(SUM_CAP)) begin
      sd_next.s = SUM_CAP;
    end else begin
      sd_next.s = qsum[31:0];
    end
    sd_next.pm = dp[DP_STEPS].pm;
    sd_next.dv = dp[DP_STEPS].dv;
  end

  // Porosity numerator product.
  always_comb begin
    se_next.tag  = sd.tag;
    se_next.flag = sd.flag;
    se_next.dbad = sd.dbad;
    se_next.n    = sd.s * sd.pm;
    se_next.dv   = sd.dv;
  end

  // Overflow test and set-up of the porosity division.
  always_comb begin
    logic ovf;
    ovf           = se.n[57:24] >= 34'(se.dv);
    kd0_next.tag  = se.tag;
    kd0_next.bad  = se.dbad || ovf;
    kd0_next.flag = se.flag || se.dbad || ovf;
    kd0_next.r    = se.n[51:24];
    kd0_next.nlo  = se.n[23:0];
    kd0_next.q    = '0;
    kd0_next.dv   = se.dv;
  end

  // Restoring division by the porosity denominator, one bit per stage.
  for (genvar j = 0; j < KD_STEPS; j++) begin : g_kd
    kd_t         nx;
    logic [28:0] r2;
    always_comb begin
      nx = kd[j];
      r2 = {kd[j].r, kd[j].nlo[KD_STEPS-1-j]};
      if (r2 >= {1'b0, kd[j].dv}) begin
        nx.r = 28'(r2 - {1'b0, kd[j].dv});
        nx.q = {kd[j].q[22:0], 1'b1};
      end else begin
        nx.r = r2[27:0];
        nx.q = {kd[j].q[22:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        kd[j+1] <= nx;
      end
    end
  end

  // Result with saturation.
  always_comb begin
    out_next.cell_tag     = kd[KD_STEPS].tag;
    out_next.conductivity = kd[KD_STEPS].bad ? RES_MAX : kd[KD_STEPS].q;
    out_next.saturated    = kd[KD_STEPS].flag;
  end

  // Payload registers of the single stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0]    <= sq0_next;
      sa       <= sa_next;
      sb       <= sb_next;
      dp[0]    <= dp0_next;
      sd       <= sd_next;
      se       <= se_next;
      kd[0]    <= kd0_next;
      out_data <= out_next;
    end
  end

  // The square-root remainder never exceeds twice the root.
  a_sq_rem: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ_STEPS] |-> (sq[SQ_STEPS].rem <= {2'b00, sq[SQ_STEPS].root, 1'b0}))
    else $error("square-root remainder out of range");

  // A well-formed phonon division leaves a remainder below the divisor.
  a_dp_rem: assert property (@(posedge clk) disable iff (rst)
    dp_v[DP_STEPS] && !dp[DP_STEPS].dbad && !dp[DP_STEPS].dsmall
      |-> (dp[DP_STEPS].r < dp[DP_STEPS].d))
    else $error("phonon division remainder not below divisor");

  // Likewise for the porosity division when it has not overflowed.
  a_kd_rem: assert property (@(posedge clk) disable iff (rst)
    kd_v[KD_STEPS] && !kd[KD_STEPS].bad |-> (kd[KD_STEPS].r < kd[KD_STEPS].dv))
    else $error("porosity division remainder not below divisor");

  // A stalled output freezes the square-root, phonon and porosity valid bits.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(sq_v) && $stable(dp_v) && $stable(kd_v)))
    else $error("pipeline moved during a stall");

endmodule

// File: sim/mox_fuel_thermal_conductivity_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MOX fuel thermal conductivity - block-level test
// Drives mesh cells through the conductivity pipeline with random idling on
// both sides. It predicts each result with an independent fixed-point model
// and compares every output transfer, in order, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module mox_fuel_thermal_conductivity_top_test;
  import mftc_pkg::*;

  localparam int PIPE_LATENCY = 81;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  mftc_in_t in_data;
  logic out_valid;
  logic out_ready;
  mftc_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copies of the coefficient registers.
  logic [PHONON_COEFF_W-1:0] model_phonon_b;
  logic [CUBIC_COEFF_W-1:0]  model_cubic_c;

  mftc_out_t pending_results[$];
  int mismatches;
  int quiet_cycles;
  bit send_idle_en;
  bit recv_idle_en;
  int recv_hold_cycles;
  int recv_burst;

  mox_fuel_thermal_conductivity_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Integer square root, floor.
  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Expected conductivity of one cell under the current coefficients.
  function automatic mftc_out_t predict_conductivity(input mftc_in_t item);
    mftc_out_t res;
    longint rad;
    longint root;
    longint tau;
    longint denom;
    longint unsigned phonon;
    longint unsigned cube;
    longint unsigned elec;
    longint unsigned total;
    longint unsigned poro;
    longint unsigned k;
    logic flag;
    flag = 1'b0;
    rad = (64'sd131072 - longint'(item.om_ratio)) * 64'sd65536 + 64'sd39986146;
    // A radicand below zero is clamped and flagged.
    if (rad < 0) begin
      rad = 0;
      flag = 1'b1;
    end
    root = longint'(isqrt(longint'(rad)));
    tau = longint'((64'(item.burnup) * 64'd11 * (64'd1 << 32)) / 64'd23750000);
    denom = root * 64'sd100139 - 64'sd453119050 + tau
          + longint'((64'(model_phonon_b) * 64'(item.temperature)) >> 4);
    res.cell_tag = item.cell_id;
    if (denom <= 0) begin
      k = 64'hFF_FFFF;
      flag = 1'b1;
    end else begin
      phonon = (64'd1 << 48) / longint'(denom);
      cube = 64'(item.temperature) * 64'(item.temperature) * 64'(item.temperature);
      elec = (64'(model_cubic_c) * (cube >> 24)
             + ((64'(model_cubic_c) * (cube & 64'hFF_FFFF)) >> 24)) >> 20;
      total = phonon + elec;
      if (total > (64'd1 << 31)) total = 64'd1 << 31;
      poro = (item.porosity_frac > 16'd62259) ? 64'd62259 : 64'(item.porosity_frac);
      k = (total * (64'd65536 - poro) * 64'd1000) / (64'd864 * (64'd65536 + 2 * poro));
      if (k > 64'hFF_FFFF) begin
        k = 64'hFF_FFFF;
        flag = 1'b1;
      end
    end
    res.conductivity = k[COND_W-1:0];
    res.saturated = flag;
    return res;
  endfunction

  // Sends one cell, with an optional idle burst first.
  task automatic send_cell(input mftc_in_t item);
    int gap;
    gap = 0;
    if (send_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_conductivity(item));
  endtask

  task automatic end_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes one register; only called while the pipeline is empty.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PHONON_TEMP_COEFF) model_phonon_b = value;
    else if (idx == REG_ELECTRONIC_CUBIC_COEFF) model_cubic_c = value[CUBIC_COEFF_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    end_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic mftc_in_t make_cell(input logic [15:0] t, input logic [17:0] bu,
                                         input logic [15:0] p, input logic [17:0] om);
    mftc_in_t c;
    c.cell_id = 20'($urandom_range(0, 1048575));
    c.temperature = t;
    c.burnup = bu;
    c.porosity_frac = p;
    c.om_ratio = om;
    return c;
  endfunction

  // Mostly physical cells near stoichiometry, sometimes any values, with O/M up to 196607.
  function automatic mftc_in_t random_cell();
    if ($urandom_range(0, 3) == 0)
      return make_cell(16'($urandom_range(0, 65535)), 18'($urandom_range(0, 262143)),
                       16'($urandom_range(0, 65535)), 18'($urandom_range(0, 196607)));
    return make_cell(16'($urandom_range(4800, 48000)), 18'($urandom_range(0, 100000)),
                     16'($urandom_range(0, 13000)), 18'($urandom_range(128000, 131700)));
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_cell(random_cell());
  endtask

  // Field extremes and the special cases under reset coefficients.
  task automatic test_directed_cells();
    mftc_in_t c;
    c = make_cell(16'd4800, 18'd0, 16'd0, 18'd131072);
    c.cell_id = '0;
    send_cell(c);
    c.cell_id = '1;
    send_cell(c);
    send_cell(make_cell(16'd0, 18'd0, 16'd0, 18'd0));
    send_cell(make_cell(16'd65535, 18'd262143, 16'd65535, 18'd196607));
    send_cell(make_cell(16'd65535, 18'd0, 16'd0, 18'd131072));
    send_cell(make_cell(16'd16000, 18'd262143, 16'd3277, 18'd131072));
    // Porosity just below, at and above the cap.
    send_cell(make_cell(16'd16000, 18'd30000, 16'd62258, 18'd131000));
    send_cell(make_cell(16'd16000, 18'd30000, 16'd62259, 18'd131000));
    send_cell(make_cell(16'd16000, 18'd30000, 16'd62260, 18'd131000));
    send_cell(make_cell(16'd16000, 18'd30000, 16'd65535, 18'd131000));
    // Radicand at the edge of going negative, then clamped.
    send_cell(make_cell(16'd16000, 18'd0, 16'd0, 18'd131682));
    send_cell(make_cell(16'd16000, 18'd0, 16'd0, 18'd131683));
    // Clamped radicand at zero temperature gives a negative denominator.
    send_cell(make_cell(16'd0, 18'd0, 16'd0, 18'd196607));
    send_cell(make_cell(16'd0, 18'd5000, 16'd1000, 18'd150000));
    // More cells with small radicands, then mid-range fields.
    send_cell(make_cell(16'd0, 18'd0, 16'd0, 18'd131100));
    send_cell(make_cell(16'd2, 18'd1, 16'd0, 18'd131682));
    send_cell(make_cell(16'd43690, 18'd131072, 16'd21845, 18'd65536));
    send_cell(make_cell(16'd21845, 18'd87381, 16'd43690, 18'd87381));
    drain();
  endtask

  // Coefficient extremes, masking of the cubic register and unused indexes.
  task automatic test_coeff_settings();
    write_reg(REG_PHONON_TEMP_COEFF, 24'd0);
    write_reg(REG_ELECTRONIC_CUBIC_COEFF, 24'd0);
    send_cell(make_cell(16'd0, 18'd0, 16'd0, 18'd131072));
    send_random(30);
    drain();
    write_reg(REG_PHONON_TEMP_COEFF, 24'hFF_FFFF);
    write_reg(REG_ELECTRONIC_CUBIC_COEFF, 24'hFF_FFFF);
    send_cell(make_cell(16'd65535, 18'd262143, 16'd0, 18'd0));
    send_random(30);
    drain();
    write_reg(2'd2, 24'd0);
    write_reg(2'd3, 24'hAB_CDEF);
    write_reg(REG_ELECTRONIC_CUBIC_COEFF, 24'hF0_0001);
    send_random(30);
    drain();
    write_reg(REG_PHONON_TEMP_COEFF, 24'($urandom_range(0, 16777215)));
    write_reg(REG_ELECTRONIC_CUBIC_COEFF, 24'($urandom_range(0, 1048575)));
    send_random(30);
    drain();
    write_reg(REG_PHONON_TEMP_COEFF, PHONON_COEFF_RST);
    write_reg(REG_ELECTRONIC_CUBIC_COEFF, 24'(CUBIC_COEFF_RST));
  endtask

  task automatic test_random_cells();
    send_random(350);
    drain();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall.
  task automatic test_output_stall();
    recv_hold_cycles = 300;
    send_random(150);
    drain();
  endtask

  task automatic test_full_rate();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    send_random(100);
    drain();
  endtask

  // Receiver ready: random bursts, or a counted long hold-off.
  initial begin
    out_ready = 1'b0;
    recv_burst = 0;
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ready <= 1'b0;
      end else if (recv_burst > 0) begin
        recv_burst--;
        out_ready <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        recv_burst = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares every output transfer against the oldest prediction.
  always @(posedge clk) begin
    mftc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: tag %0d k %0d sat %0d",
                   out_data.cell_tag, out_data.conductivity, out_data.saturated);
      end else begin
        want = pending_results.pop_front();
        if (out_data.cell_tag !== want.cell_tag
            || out_data.conductivity !== want.conductivity
            || out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected tag %0d k %0d sat %0d, got tag %0d k %0d sat %0d",
                     want.cell_tag, want.conductivity, want.saturated,
                     out_data.cell_tag, out_data.conductivity, out_data.saturated);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    recv_hold_cycles = 0;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    model_phonon_b = PHONON_COEFF_RST;
    model_cubic_c = CUBIC_COEFF_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cells();
    test_coeff_settings();
    test_random_cells();
    test_output_stall();
    test_full_rate();

    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
